[rtl/png_scanline_unfilter_rgba8_assert.svh]
// Assertion macros shared by the scanline unfilter modules.
`ifndef PNG_SCANLINE_UNFILTER_RGBA8_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_RGBA8_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PNGUNF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PNGUNF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pngunf_pkg.sv]
`timescale 1ns / 1ps

package pngunf_pkg;

  // Fixed field widths
  localparam int ByteW         = 8;
  localparam int ChannelW      = 2;
  localparam int ImageWidthW   = 11;
  localparam int BytesPerPixel = 4;

  // Default line store size in pixels
  localparam int MaxWidthDefault = 1024;

  // PNG filter types; codes 5..7 are invalid
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // Control of the transaction held in the reconstruction stage
  typedef struct packed {
    logic    bad;
    logic    first_row;
    logic    first_px;
    logic    last;
    filter_e filter;
  } s1_ctrl_t;

  // Absolute value of a narrow signed difference
  function automatic logic [8:0] abs10(input logic signed [9:0] v);
    logic signed [9:0] n;
    n = -v;
    abs10 = v[9] ? n[8:0] : v[8:0];
  endfunction

  // Paeth predictor
  function automatic logic [ByteW-1:0] paeth(input logic [ByteW-1:0] a,
                                             input logic [ByteW-1:0] b,
                                             input logic [ByteW-1:0] c);
    logic signed [9:0] ea, eb, ec;
    logic [8:0] pa, pb, pc;
    ea = signed'({2'b00, a});
    eb = signed'({2'b00, b});
    ec = signed'({2'b00, c});
    pa = abs10(eb - ec);
    pb = abs10(ea - ec);
    pc = abs10(ea + eb - ec - ec);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

[rtl/pngunf_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port.
module pngunf_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pngunf_front.sv]
`timescale 1ns / 1ps
`include "png_scanline_unfilter_rgba8_assert.svh"

// Row tracking: filter byte parsing, column count, line store read address.
module pngunf_front #(
  parameter int MaxWidth = pngunf_pkg::MaxWidthDefault,
  parameter int LenW     = $clog2(4 * MaxWidth + 1),
  parameter int XW       = $clog2(4 * MaxWidth)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               image_width_we_i,
  input  logic [pngunf_pkg::ImageWidthW-1:0] image_width_i,
  input  logic                               accept_i,
  input  logic [pngunf_pkg::ByteW-1:0]       raw_byte_i,
  input  logic                               image_start_i,
  output logic                               item_valid_o,
  output pngunf_pkg::s1_ctrl_t               item_o,
  output logic [XW-1:0]                      item_x_o,
  output logic                               rd_en_o
);

  localparam int MaxLen = pngunf_pkg::BytesPerPixel * MaxWidth;

  logic [LenW-1:0]     len_q, len_d;
  logic [LenW-1:0]     col_q, col_d;
  logic                first_q, first_d;
  logic                halted_q, halted_d;
  pngunf_pkg::filter_e filter_q, filter_d;
  logic [31:0]         wc;
  logic [LenW-1:0]     xfull;
  logic                last;
  logic                near_start;

  // Row length in bytes, clamped when written
  always_comb begin
    wc = 32'(image_width_i);
    if (wc == 32'd0) begin
      wc = 32'd1;
    end else if (wc > 32'(MaxWidth)) begin
      wc = 32'(MaxWidth);
    end
    len_d = image_width_we_i ? LenW'(wc << 2) : len_q;
  end

  // Data byte column, clamped to the current row
  always_comb begin
    xfull = col_q - LenW'(1);
    if (xfull >= len_q) begin
      xfull = len_q - LenW'(1);
    end
    last = (xfull + LenW'(1)) >= len_q;
    // fewer than a pixel of bytes since the filter byte: no left neighbor yet
    near_start = (col_q <= LenW'(pngunf_pkg::BytesPerPixel));
  end

  // Next state and stage-one transaction
  always_comb begin
    col_d        = col_q;
    first_d      = first_q;
    halted_d     = halted_q;
    filter_d     = filter_q;
    item_valid_o = 1'b0;
    item_o       = '{bad: 1'b0, first_row: first_q, first_px: near_start, last: last,
                     filter: filter_q};
    rd_en_o      = 1'b0;
    if (accept_i) begin
      if (image_start_i || (!halted_q && col_q == '0)) begin
        // Filter byte
        first_d = image_start_i ? 1'b1 : first_q;
        if (raw_byte_i > pngunf_pkg::ByteW'(pngunf_pkg::FILT_PAETH)) begin
          halted_d     = 1'b1;
          col_d        = '0;
          item_valid_o = 1'b1;
          item_o.bad   = 1'b1;
        end else begin
          halted_d = 1'b0;
          col_d    = LenW'(1);
          filter_d = pngunf_pkg::filter_e'(raw_byte_i[2:0]);
        end
      end else if (!halted_q) begin
        // Data byte
        item_valid_o = 1'b1;
        rd_en_o      = 1'b1;
        if (last) begin
          col_d   = '0;
          first_d = 1'b0;
        end else begin
          col_d = xfull + LenW'(2);
        end
      end
    end
  end

  assign item_x_o = xfull[XW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LenW'(pngunf_pkg::BytesPerPixel);
      col_q    <= '0;
      first_q  <= 1'b1;
      halted_q <= 1'b1;
      filter_q <= pngunf_pkg::FILT_NONE;
    end else begin
      len_q    <= len_d;
      col_q    <= col_d;
      first_q  <= first_d;
      halted_q <= halted_d;
      filter_q <= filter_d;
    end
  end

  `PNGUNF_ASSERT_IMP(a_halt_col, clk_i, rst_ni, halted_q, col_q == '0, "halted mid-row")
  `PNGUNF_ASSERT_IMP(a_len_range, clk_i, rst_ni, 1'b1,
                     len_q != '0 && len_q <= LenW'(MaxLen), "row length out of range")

endmodule

[rtl/pngunf_dpath.sv]
`timescale 1ns / 1ps
`include "png_scanline_unfilter_rgba8_assert.svh"

// Reconstruction stage and result register.
module pngunf_dpath #(
  parameter int MaxWidth = pngunf_pkg::MaxWidthDefault,
  parameter int XW       = $clog2(4 * MaxWidth)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  logic                            item_valid_i,
  input  pngunf_pkg::s1_ctrl_t            item_i,
  input  logic [XW-1:0]                   item_x_i,
  input  logic [pngunf_pkg::ByteW-1:0]    raw_byte_i,
  input  logic [pngunf_pkg::ByteW-1:0]    upper_i,
  output logic                            ready_o,
  output logic                            wr_en_o,
  output logic [XW-1:0]                   wr_addr_o,
  output logic [pngunf_pkg::ByteW-1:0]    wr_data_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pngunf_pkg::ByteW-1:0]    pixel_byte_o,
  output logic [pngunf_pkg::ChannelW-1:0] channel_o,
  output logic                            row_end_o,
  output logic                            bad_filter_o
);

  localparam int BW = pngunf_pkg::ByteW;
  localparam int HW = pngunf_pkg::BytesPerPixel * BW;

  pngunf_pkg::s1_ctrl_t           s1_q;
  logic                           s1_valid_q;
  logic [XW-1:0]                  s1_x_q;
  logic [BW-1:0]                  s1_raw_q;
  logic [HW-1:0]                  left_q, upl_q;
  logic                           out_valid_q;
  logic [BW-1:0]                  pix_q;
  logic [pngunf_pkg::ChannelW-1:0] chan_q;
  logic                           rend_q, bad_q;
  logic                           s1_adv;
  logic [BW-1:0]                  a, b, c, pred, val;
  logic [BW:0]                    sum_ab;

  // Handshake: stage one moves when the result register is free or drains
  assign s1_adv  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign ready_o = !s1_valid_q || s1_adv;

  // Neighbors; left and upper-left are zero on the first pixel of a row
  assign a      = s1_q.first_px ? '0 : left_q[HW-1 -: BW];
  assign c      = s1_q.first_px ? '0 : upl_q[HW-1 -: BW];
  assign b      = s1_q.first_row ? '0 : upper_i;
  assign sum_ab = {1'b0, a} + {1'b0, b};

  // Predictor by filter type
  always_comb begin
    case (s1_q.filter)
      pngunf_pkg::FILT_SUB:   pred = a;
      pngunf_pkg::FILT_UP:    pred = b;
      pngunf_pkg::FILT_AVG:   pred = sum_ab[BW:1];
      pngunf_pkg::FILT_PAETH: pred = pngunf_pkg::paeth(a, b, c);
      default:                pred = '0;
    endcase
    val = s1_raw_q + pred;
  end

  // Line store write-back
  assign wr_en_o   = s1_adv && !s1_q.bad;
  assign wr_addr_o = s1_x_q;
  assign wr_data_o = val;

  // Stage-one and result control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      upl_q       <= '0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= item_valid_i;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (wr_en_o) begin
        left_q <= {left_q[HW-BW-1:0], val};
        upl_q  <= {upl_q[HW-BW-1:0], b};
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i && item_valid_i) begin
      s1_q     <= item_i;
      s1_x_q   <= item_x_i;
      s1_raw_q <= raw_byte_i;
    end
    if (s1_adv) begin
      pix_q  <= s1_q.bad ? '0 : val;
      chan_q <= s1_q.bad ? '0 : s1_x_q[1:0];
      rend_q <= s1_q.bad ? 1'b0 : s1_q.last;
      bad_q  <= s1_q.bad;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pixel_byte_o = pix_q;
  assign channel_o    = chan_q;
  assign row_end_o    = rend_q;
  assign bad_filter_o = bad_q;

  `PNGUNF_ASSERT_IMP(a_bad_zero, clk_i, rst_ni, out_valid_q && bad_q,
                     pix_q == '0 && chan_q == '0 && !rend_q, "bad filter result not zeroed")
  `PNGUNF_ASSERT_IMP(a_row_end_alpha, clk_i, rst_ni, out_valid_q && rend_q,
                     chan_q == pngunf_pkg::ChannelW'(3), "row ended off a pixel boundary")
  `PNGUNF_ASSERT_NXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv,
                     s1_valid_q && $stable(s1_x_q), "stage one lost a stalled transaction")

endmodule

[rtl/png_scanline_unfilter_rgba8.sv]
`timescale 1ns / 1ps

// PNG scanline filter reconstruction, 8-bit RGBA, one byte per transaction.
// Pipeline: an accepted byte is held in the stage-one register and then in the
//   result register, which drives the outputs.
// Throughput: one byte per cycle; an output stall stalls the input in the same
//   cycle once the input and result registers both hold a transaction.
// Reset: block waits for image_start, width 1 pixel; line store is not cleared.
module png_scanline_unfilter_rgba8 #(
  parameter int MaxWidth = pngunf_pkg::MaxWidthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               image_width_we_i,
  input  logic [pngunf_pkg::ImageWidthW-1:0] image_width_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pngunf_pkg::ByteW-1:0]       raw_byte_i,
  input  logic                               image_start_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pngunf_pkg::ByteW-1:0]       pixel_byte_o,
  output logic [pngunf_pkg::ChannelW-1:0]    channel_o,
  output logic                               row_end_o,
  output logic                               bad_filter_o
);

  localparam int Depth = pngunf_pkg::BytesPerPixel * MaxWidth;
  localparam int XW    = $clog2(Depth);
  localparam int LenW  = $clog2(Depth + 1);

  pngunf_pkg::s1_ctrl_t           item;
  logic                           item_valid;
  logic [XW-1:0]                  item_x;
  logic                           rd_en, ready, accept;
  logic                           wr_en;
  logic [XW-1:0]                  wr_addr;
  logic [pngunf_pkg::ByteW-1:0]   wr_data, upper;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  pngunf_front #(
    .MaxWidth (MaxWidth),
    .LenW     (LenW),
    .XW       (XW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .image_width_we_i (image_width_we_i),
    .image_width_i    (image_width_i),
    .accept_i         (accept),
    .raw_byte_i       (raw_byte_i),
    .image_start_i    (image_start_i),
    .item_valid_o     (item_valid),
    .item_o           (item),
    .item_x_o         (item_x),
    .rd_en_o          (rd_en)
  );

  // Previous reconstructed row
  pngunf_ram #(
    .Width (pngunf_pkg::ByteW),
    .Depth (Depth)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (item_x),
    .rdata_o (upper)
  );

  pngunf_dpath #(
    .MaxWidth (MaxWidth),
    .XW       (XW)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_x_i     (item_x),
    .raw_byte_i   (raw_byte_i),
    .upper_i      (upper),
    .ready_o      (ready),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_byte_o (pixel_byte_o),
    .channel_o    (channel_o),
    .row_end_o    (row_end_o),
    .bad_filter_o (bad_filter_o)
  );

endmodule
